[hw/rtl/fifoq_pkg.sv]
package fifoq_pkg;

	localparam int DEPTH = 16;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	localparam int PLATE_W = 32;
	localparam int AXLES_W = 4;
	localparam int REC_W = PLATE_W + AXLES_W;
	localparam int TDATA_W = ((REC_W + 7) / 8) * 8;
	localparam int S_TUSER_W = 2;
	localparam int M_TUSER_W = 3;

	typedef enum logic [1:0] {
		REQ_PUSH  = 2'd0,
		REQ_POP   = 2'd1,
		REQ_LIST  = 2'd2,
		REQ_DRAIN = 2'd3
	} fifoq_req_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} fifoq_status_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_WALK = 1'b1
	} fifoq_state_t;

	function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
		logic [IDX_W-1:0] r;
		if (i == IDX_W'(DEPTH - 1)) begin
			r = '0;
		end else begin
			r = i + 1'b1;
		end
		return r;
	endfunction

endpackage

[hw/rtl/fifo_queue_with_list_and_drain_top.sv]
// Bounded FIFO of vehicle records (32-bit plate, 4-bit axle count).
// Requests enter on the s_ group: s_tuser carries the request kind (push,
// pop, list, drain), s_tdata the record for a push. Results leave on the m_
// group: m_tuser carries the status and the has-record flag, m_tdata the
// listed record, and m_tlast marks the final beat of each request.
// Push and pop: the status beat is presented the cycle after the request
// beat, and a new request is taken as soon as the output register is free.
// List and drain read the record memory one entry a cycle while m_tready
// stays high, through its registered read port, so a queue of N records
// yields N beats at one beat per cycle via the read and output registers.
// An empty queue answers list and drain with a single empty-status beat.
// Requests are taken one at a time: s_tready stays low while a walk runs.
// When the receiver holds m_tready low, the output register holds its beat,
// and the walk stops issuing reads until the beat is taken; no beat is lost.
// Reset clears the pointers, the count and all control state; the queue is
// empty afterwards. The record memory itself is not cleared.
module fifo_queue_with_list_and_drain_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// [31:0] plate, [35:32] axles, rest zero
	input  logic [fifoq_pkg::TDATA_W-1:0]   s_tdata,
	// [1:0] req_type
	input  logic [fifoq_pkg::S_TUSER_W-1:0] s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// [31:0] out_plate, [35:32] out_axles, rest zero
	output logic [fifoq_pkg::TDATA_W-1:0]   m_tdata,
	// [1:0] status, [2] has_record
	output logic [fifoq_pkg::M_TUSER_W-1:0] m_tuser,
	output logic                           m_tlast
);

	localparam int IDX_W = fifoq_pkg::IDX_W;
	localparam int CNT_W = fifoq_pkg::CNT_W;
	localparam int REC_W = fifoq_pkg::REC_W;
	localparam int PLATE_W = fifoq_pkg::PLATE_W;
	localparam int AXLES_W = fifoq_pkg::AXLES_W;
	localparam int DEPTH = fifoq_pkg::DEPTH;

	logic [REC_W-1:0] mem [DEPTH];

	fifoq_pkg::fifoq_state_t state_q, state_nxt;
	logic [IDX_W-1:0] head_q, tail_q, walk_idx_q;
	logic [CNT_W-1:0] count_q, remain_q;
	logic rd_pend_s1, rd_last_s1;
	logic [REC_W-1:0] rd_data_s1;

	logic out_valid_q, out_has_q, out_last_q;
	fifoq_pkg::fifoq_status_t out_status_q;
	logic [PLATE_W-1:0] out_plate_q;
	logic [AXLES_W-1:0] out_axles_q;

	logic out_free, accept, rd_issue, wr_en, is_full, is_empty, walk_start;
	fifoq_pkg::fifoq_req_t req;

	assign out_free = !out_valid_q || m_tready;
	assign accept = s_tvalid && s_tready;
	assign req = fifoq_pkg::fifoq_req_t'(s_tuser[1:0]);
	assign is_full = (count_q == CNT_W'(DEPTH));
	assign is_empty = (count_q == '0);
	assign wr_en = accept && (req == fifoq_pkg::REQ_PUSH) && !is_full;
	assign walk_start = accept && !is_empty &&
		((req == fifoq_pkg::REQ_LIST) || (req == fifoq_pkg::REQ_DRAIN));

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			fifoq_pkg::ST_IDLE: begin
				if (walk_start) begin
					state_nxt = fifoq_pkg::ST_WALK;
				end
			end
			fifoq_pkg::ST_WALK: begin
				if (remain_q == '0 && (!rd_pend_s1 || out_free)) begin
					state_nxt = fifoq_pkg::ST_IDLE;
				end
			end
			default: state_nxt = fifoq_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		rd_issue = 1'b0;
		case (state_q)
			fifoq_pkg::ST_IDLE: begin
				s_tready = out_free;
			end
			fifoq_pkg::ST_WALK: begin
				// A new read may start only once the previous read word can move on.
				rd_issue = (remain_q != '0) && (!rd_pend_s1 || out_free);
			end
			default: begin
				s_tready = 1'b0;
				rd_issue = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[tail_q] <= s_tdata[REC_W-1:0];
		end
		if (rd_issue) begin
			rd_data_s1 <= mem[walk_idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fifoq_pkg::ST_IDLE;
			head_q <= '0;
			tail_q <= '0;
			count_q <= '0;
			walk_idx_q <= '0;
			remain_q <= '0;
			rd_pend_s1 <= 1'b0;
			rd_last_s1 <= 1'b0;
			out_valid_q <= 1'b0;
			out_has_q <= 1'b0;
			out_last_q <= 1'b0;
			out_status_q <= fifoq_pkg::STAT_OK;
		end else begin
			state_q <= state_nxt;
			rd_pend_s1 <= rd_issue || (rd_pend_s1 && !out_free);
			if (rd_issue) begin
				walk_idx_q <= fifoq_pkg::ring_next(walk_idx_q);
				remain_q <= remain_q - 1'b1;
				rd_last_s1 <= (remain_q == CNT_W'(1));
			end
			if (accept) begin
				case (req)
					fifoq_pkg::REQ_PUSH: begin
						if (!is_full) begin
							tail_q <= fifoq_pkg::ring_next(tail_q);
							count_q <= count_q + 1'b1;
						end
					end
					fifoq_pkg::REQ_POP: begin
						if (!is_empty) begin
							head_q <= fifoq_pkg::ring_next(head_q);
							count_q <= count_q - 1'b1;
						end
					end
					fifoq_pkg::REQ_LIST, fifoq_pkg::REQ_DRAIN: begin
						walk_idx_q <= head_q;
						remain_q <= count_q;
						// Draining empties the queue up front; nothing writes during the walk.
						if (req == fifoq_pkg::REQ_DRAIN) begin
							head_q <= tail_q;
							count_q <= '0;
						end
					end
					default: begin
						count_q <= count_q;
					end
				endcase
			end
			if (accept && !walk_start) begin
				out_valid_q <= 1'b1;
				out_has_q <= 1'b0;
				out_last_q <= 1'b1;
				if (req == fifoq_pkg::REQ_PUSH) begin
					out_status_q <= is_full ? fifoq_pkg::STAT_FULL : fifoq_pkg::STAT_OK;
				end else begin
					out_status_q <= is_empty ? fifoq_pkg::STAT_EMPTY : fifoq_pkg::STAT_OK;
				end
			end else if (rd_pend_s1 && out_free) begin
				out_valid_q <= 1'b1;
				out_has_q <= 1'b1;
				out_last_q <= rd_last_s1;
				out_status_q <= fifoq_pkg::STAT_OK;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !walk_start) begin
			out_plate_q <= '0;
			out_axles_q <= '0;
		end else if (rd_pend_s1 && out_free) begin
			out_plate_q <= rd_data_s1[PLATE_W-1:0];
			out_axles_q <= rd_data_s1[REC_W-1:PLATE_W];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {{(fifoq_pkg::TDATA_W - REC_W){1'b0}}, out_axles_q, out_plate_q};
	assign m_tuser = {out_has_q, out_status_q};
	assign m_tlast = out_last_q;

	// Ring consistency: head plus count, wrapped, lands on tail.
	logic [CNT_W:0] chk_sum, chk_wrap;
	assign chk_sum = (CNT_W + 1)'(head_q) + (CNT_W + 1)'(count_q);
	assign chk_wrap = (chk_sum >= (CNT_W + 1)'(DEPTH)) ? chk_sum - (CNT_W + 1)'(DEPTH) : chk_sum;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count exceeds depth");

	a_ring_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		chk_wrap[IDX_W-1:0] == tail_q)
		else $error("head, tail and count disagree");

	a_read_only_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_s1 |-> state_q == fifoq_pkg::ST_WALK)
		else $error("read word pending outside a walk");

	a_walk_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_pend_s1 && rd_last_s1 && out_free) |=> state_q == fifoq_pkg::ST_IDLE)
		else $error("walk did not end after its last record");

	a_no_write_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == fifoq_pkg::ST_WALK |-> !wr_en)
		else $error("record written during a walk");

endmodule

[dv/fifo_queue_with_list_and_drain_top_tb.sv]
module fifo_queue_with_list_and_drain_top_tb;

	localparam int NUM_ITEMS = 420;
	localparam int IDLE_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;
	localparam int MAX_PRINTED = 40;

	localparam int DEPTH = fifoq_pkg::DEPTH;
	localparam int PLATE_W = fifoq_pkg::PLATE_W;
	localparam int AXLES_W = fifoq_pkg::AXLES_W;
	localparam int TDATA_W = fifoq_pkg::TDATA_W;
	localparam int S_TUSER_W = fifoq_pkg::S_TUSER_W;
	localparam int M_TUSER_W = fifoq_pkg::M_TUSER_W;

	typedef struct {
		fifoq_pkg::fifoq_req_t kind;
		logic [PLATE_W-1:0]    plate;
		logic [AXLES_W-1:0]    axles;
	} vehicle_req_t;

	typedef struct {
		fifoq_pkg::fifoq_status_t status;
		logic                     has_rec;
		logic [PLATE_W-1:0]       plate;
		logic [AXLES_W-1:0]       axles;
		logic                     last;
	} queue_beat_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [TDATA_W-1:0]     s_tdata = '0;
	logic [S_TUSER_W-1:0]   s_tuser = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [TDATA_W-1:0]     m_tdata;
	logic [M_TUSER_W-1:0]   m_tuser;
	logic                   m_tlast;

	vehicle_req_t pending_reqs[$];
	queue_beat_t  expected_beats[$];
	vehicle_req_t offered;

	// Shadow copy of the vehicle queue.
	logic [PLATE_W-1:0] shadow_plate[DEPTH];
	logic [AXLES_W-1:0] shadow_axles[DEPTH];
	int                 shadow_head = 0;
	int                 shadow_tail = 0;
	int                 shadow_count = 0;

	int          mismatches = 0;
	int          beats_seen = 0;
	int          idle_cycles = 0;
	int unsigned send_gap = 0;
	int unsigned send_steady = 0;
	int unsigned stall_left = 0;
	int unsigned ready_run = 0;
	int unsigned hold_left = 0;
	logic        hold_done = 1'b0;

	fifo_queue_with_list_and_drain_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	function automatic int step_ring(input int i);
		return (i + 1) % DEPTH;
	endfunction

	// Most gaps are short; a few are long.
	function automatic int unsigned random_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	task automatic add_req(input fifoq_pkg::fifoq_req_t kind, input logic [PLATE_W-1:0] plate,
			input logic [AXLES_W-1:0] axles);
		vehicle_req_t rq;
		rq.kind = kind;
		rq.plate = plate;
		rq.axles = axles;
		pending_reqs.push_back(rq);
	endtask

	task automatic add_random_req(input fifoq_pkg::fifoq_req_t kind);
		add_req(kind, $urandom, AXLES_W'($urandom_range(0, 15)));
	endtask

	// Updates the shadow queue and queues the beats the request must produce.
	task automatic apply_request(input vehicle_req_t rq);
		queue_beat_t b;
		int idx;
		b.status = fifoq_pkg::STAT_OK;
		b.has_rec = 1'b0;
		b.plate = '0;
		b.axles = '0;
		b.last = 1'b1;
		case (rq.kind)
			fifoq_pkg::REQ_PUSH: begin
				if (shadow_count == DEPTH) begin
					b.status = fifoq_pkg::STAT_FULL;
				end else begin
					shadow_plate[shadow_tail] = rq.plate;
					shadow_axles[shadow_tail] = rq.axles;
					shadow_tail = step_ring(shadow_tail);
					shadow_count++;
				end
				expected_beats.push_back(b);
			end
			fifoq_pkg::REQ_POP: begin
				if (shadow_count == 0) begin
					b.status = fifoq_pkg::STAT_EMPTY;
				end else begin
					shadow_head = step_ring(shadow_head);
					shadow_count--;
				end
				expected_beats.push_back(b);
			end
			default: begin
				if (shadow_count == 0) begin
					b.status = fifoq_pkg::STAT_EMPTY;
					expected_beats.push_back(b);
				end else begin
					idx = shadow_head;
					for (int k = 0; k < shadow_count; k++) begin
						b.has_rec = 1'b1;
						b.plate = shadow_plate[idx];
						b.axles = shadow_axles[idx];
						b.last = (k == shadow_count - 1);
						expected_beats.push_back(b);
						idx = step_ring(idx);
					end
					if (rq.kind == fifoq_pkg::REQ_DRAIN) begin
						shadow_head = shadow_tail;
						shadow_count = 0;
					end
				end
			end
		endcase
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatches++;
		if (mismatches <= MAX_PRINTED) begin
			$display("beat %0d: %s mismatch, got %0h expected %0h", beats_seen, what, got, want);
		end
	endtask

	// Request driver.
	always @(posedge clk or negedge arst_n) begin
		vehicle_req_t nxt;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
			send_gap <= 0;
			send_steady <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				apply_request(offered);
			end
			if (!s_tvalid || s_tready) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
					s_tvalid <= 1'b0;
				end else if (pending_reqs.size() != 0) begin
					nxt = pending_reqs.pop_front();
					offered <= nxt;
					s_tdata <= TDATA_W'({nxt.axles, nxt.plate});
					s_tuser <= nxt.kind;
					s_tvalid <= 1'b1;
					if (send_steady != 0) begin
						send_steady <= send_steady - 1;
						send_gap <= 0;
					end else begin
						if ($urandom_range(0, 99) < 4) begin
							send_steady <= $urandom_range(20, 60);
						end
						send_gap <= random_gap();
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result receiver. One long hold-off lets the block back up into its input.
	always @(posedge clk or negedge arst_n) begin
		int unsigned r;
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left <= 0;
			ready_run <= 0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else if (!hold_done && beats_seen >= 40) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else if (ready_run != 0) begin
			ready_run <= ready_run - 1;
			m_tready <= 1'b1;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 4) begin
				ready_run <= $urandom_range(20, 60);
				m_tready <= 1'b1;
			end else if (r < 70) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b0;
				stall_left <= (r < 96) ? $urandom_range(0, 3) : $urandom_range(8, 40);
			end
		end
	end

	// Result monitor.
	always @(posedge clk) begin
		queue_beat_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_beats.size() == 0) begin
				report_mismatch("unexpected beat", 32'({m_tuser, m_tlast}), '0);
			end else begin
				want = expected_beats.pop_front();
				if (m_tuser[1:0] != want.status) begin
					report_mismatch("status", 32'(m_tuser[1:0]), 32'(want.status));
				end
				if (m_tuser[2] != want.has_rec) begin
					report_mismatch("has_record", 32'(m_tuser[2]), 32'(want.has_rec));
				end
				if (m_tdata[PLATE_W-1:0] != want.plate) begin
					report_mismatch("out_plate", m_tdata[PLATE_W-1:0], want.plate);
				end
				if (m_tdata[PLATE_W +: AXLES_W] != want.axles) begin
					report_mismatch("out_axles", 32'(m_tdata[PLATE_W +: AXLES_W]),
						32'(want.axles));
				end
				if (m_tlast != want.last) begin
					report_mismatch("last", 32'(m_tlast), 32'(want.last));
				end
			end
			beats_seen <= beats_seen + 1;
		end
	end

	// Watchdog on cycles without any beat moving.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: no beat for %0d cycles", IDLE_LIMIT);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	initial begin
		int unsigned burst;
		int unsigned mode;
		int unsigned r;
		int unsigned push_pct;
		int unsigned pop_pct;

		// Directed: empty-queue answers, field extremes, keep versus drain.
		add_req(fifoq_pkg::REQ_POP, 32'h0, 4'h0);
		add_req(fifoq_pkg::REQ_LIST, 32'hFFFF_FFFF, 4'hF);
		add_req(fifoq_pkg::REQ_DRAIN, 32'h0, 4'h0);
		add_req(fifoq_pkg::REQ_PUSH, 32'h0000_0000, 4'h0);
		add_req(fifoq_pkg::REQ_PUSH, 32'hFFFF_FFFF, 4'hF);
		add_req(fifoq_pkg::REQ_LIST, 32'h0, 4'h0);
		add_req(fifoq_pkg::REQ_POP, 32'hFFFF_FFFF, 4'hF);
		add_req(fifoq_pkg::REQ_LIST, 32'h0, 4'h0);
		add_req(fifoq_pkg::REQ_POP, 32'h0, 4'h0);
		add_req(fifoq_pkg::REQ_POP, 32'h0, 4'h0);
		add_req(fifoq_pkg::REQ_PUSH, 32'hAAAA_AAAA, 4'hA);
		add_req(fifoq_pkg::REQ_PUSH, 32'h5555_5555, 4'h5);
		add_req(fifoq_pkg::REQ_PUSH, 32'h0000_0001, 4'h1);
		add_req(fifoq_pkg::REQ_DRAIN, 32'h0, 4'h0);
		add_req(fifoq_pkg::REQ_LIST, 32'h0, 4'h0);
		add_req(fifoq_pkg::REQ_POP, 32'h0, 4'h0);
		add_req(fifoq_pkg::REQ_PUSH, 32'h8000_0000, 4'h8);
		add_req(fifoq_pkg::REQ_LIST, 32'h0, 4'h0);
		add_req(fifoq_pkg::REQ_DRAIN, 32'h0, 4'h0);

		// Random bursts that lean toward filling, emptying or mixing the queue.
		while (pending_reqs.size() < NUM_ITEMS) begin
			burst = $urandom_range(10, 30);
			mode = $urandom_range(0, 2);
			push_pct = (mode == 0) ? 75 : (mode == 1) ? 20 : 40;
			pop_pct = (mode == 0) ? 10 : (mode == 1) ? 60 : 30;
			repeat (burst) begin
				r = $urandom_range(0, 99);
				if (r < push_pct) begin
					add_random_req(fifoq_pkg::REQ_PUSH);
				end else if (r < push_pct + pop_pct) begin
					add_random_req(fifoq_pkg::REQ_POP);
				end else if (r < push_pct + pop_pct + (100 - push_pct - pop_pct) / 2) begin
					add_random_req(fifoq_pkg::REQ_LIST);
				end else begin
					add_random_req(fifoq_pkg::REQ_DRAIN);
				end
			end
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		do begin
			@(negedge clk);
		end while (pending_reqs.size() != 0 || s_tvalid || expected_beats.size() != 0);
		repeat (10) @(negedge clk);

		if (expected_beats.size() != 0) begin
			report_mismatch("beats never delivered", 32'(expected_beats.size()), '0);
		end
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/fifoq_pkg.sv
hw/rtl/fifo_queue_with_list_and_drain_top.sv
dv/fifo_queue_with_list_and_drain_top_tb.sv
